// File: hw/rtl/ebod_pkg.sv
// Shared types, widths and constants of the energy beat onset detector.
`default_nettype none
package ebod_pkg;

  // Field and state widths.
  localparam int E_W     = 16;
  localparam int DT_W    = 17;
  localparam int AVG_W   = 24;
  localparam int FOL_W   = 20;
  localparam int SINCE_W = 20;
  localparam int IDLE_W  = 22;
  localparam int CNT_W   = 32;
  localparam int PHASE_W = 3;
  localparam int DEC_W   = 12;
  localparam int PROD_W  = 38;
  localparam int EAVG_W  = 29;
  localparam int EFOL_W  = 31;
  localparam int MTR_W   = 16;
  localparam int N_W     = 30;

  // Configuration register widths.
  localparam int SENS_W  = 14;
  localparam int INTV_W  = 21;
  localparam int REL_W   = 16;
  localparam int MODE_W  = 2;
  localparam int EVERY_W = 4;
  localparam int CFG_AW  = 5;
  localparam int CFG_DW  = 32;

  // Register indexes (byte address divided by four).
  localparam logic [2:0] REG_SENS  = 3'd0;
  localparam logic [2:0] REG_INTV  = 3'd1;
  localparam logic [2:0] REG_REL   = 3'd2;
  localparam logic [2:0] REG_MODE  = 3'd3;
  localparam logic [2:0] REG_EVERY = 3'd4;

  // Orientation modes.
  localparam logic [MODE_W-1:0] MODE_DOWN   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FRONT  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TOGGLE = 2'd2;

  // Reset values of the registers.
  localparam logic [SENS_W-1:0]  SENS_RST  = 14'd5325;
  localparam logic [INTV_W-1:0]  INTV_RST  = 21'd500000;
  localparam logic [REL_W-1:0]   REL_RST   = 16'd60293;
  localparam logic [EVERY_W-1:0] EVERY_RST = 4'd3;
  localparam logic [EVERY_W-1:0] EVERY_MIN = 4'd1;
  localparam logic [EVERY_W-1:0] EVERY_MAX = 4'd8;

  // Filter coefficients in Q0.16.
  localparam logic [15:0] AVG_KEEP  = 16'd57672;
  localparam logic [12:0] AVG_ALPHA = 13'd7864;
  localparam logic [15:0] FOL_KEEP  = 16'd45875;
  localparam logic [14:0] FOL_ALPHA = 15'd19661;
  localparam int          RND_HALF  = 32768;

  // Detector limits.
  localparam logic [E_W-1:0]     MIN_E       = 16'd245;
  localparam logic [SINCE_W-1:0] REFRACT_US  = 20'd100000;
  localparam logic [SINCE_W-1:0] SINCE_MAX   = 20'hFFFFF;
  localparam logic [SINCE_W-1:0] SINCE_RST   = 20'd1000000;
  localparam logic [IDLE_W-1:0]  IDLE_MAX    = 22'h3FFFFF;
  localparam logic [MTR_W-1:0]   MTR_MAX     = 16'hFFFF;

  // Peak fall per frame: (dt*4096 + 78125) / 156250, by reciprocal 2^40/156250.
  localparam logic [16:0] DEC_OFS   = 17'd78125;
  localparam logic [17:0] DEC_DIV   = 18'd156250;
  localparam logic [22:0] DEC_RECIP = 23'd7036874;

  // Result queue depth; covers the pipeline so one word is taken per cycle while results are read.
  localparam int OQ_DEPTH = 8;

  typedef struct packed {
    logic [SENS_W-1:0]  sens;
    logic [INTV_W-1:0]  interval;
    logic [REL_W-1:0]   rel;
    logic [MODE_W-1:0]  mode;
    logic [EVERY_W-1:0] every;
  } cfg_t;

  typedef struct packed {
    logic              mode_wr;
    logic [MODE_W-1:0] mode_val;
  } cfg_evt_t;

  typedef struct packed {
    logic [E_W-1:0]    e;
    logic              have;
    logic [DT_W-1:0]   dt;
    logic [EAVG_W-1:0] eavg_m;
    logic [EFOL_W-1:0] efol_m;
    logic [DEC_W-1:0]  dec;
  } pre_t;

  typedef struct packed {
    logic [E_W-1:0]    e;
    logic              have;
    logic [DT_W-1:0]   dt;
    logic [FOL_W-1:0]  fol;
    logic [FOL_W-1:0]  pk;
    logic [PROD_W-1:0] prod;
  } trk_t;

  typedef struct packed {
    logic              beat;
    logic [CNT_W-1:0]  beat_total;
    logic              front;
    logic [MTR_W-1:0]  meter_energy;
    logic [MTR_W-1:0]  meter_peak;
    logic [MTR_W-1:0]  meter_threshold;
  } res_t;

endpackage
`default_nettype wire

// File: hw/rtl/ebod_cfg.sv
// Configuration register file with an APB-style access port.
`default_nettype none
module ebod_cfg (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [ebod_pkg::CFG_AW-1:0]   paddr,
  input  wire logic [ebod_pkg::CFG_DW-1:0]   pwdata,
  output logic      [ebod_pkg::CFG_DW-1:0]   prdata,
  output logic                               pready,
  output ebod_pkg::cfg_t                     cfg,
  output ebod_pkg::cfg_evt_t                 evt
);

  logic [ebod_pkg::SENS_W-1:0]  sens_r;
  logic [ebod_pkg::INTV_W-1:0]  intv_r;
  logic [ebod_pkg::REL_W-1:0]   rel_r;
  logic [ebod_pkg::MODE_W-1:0]  mode_r;
  logic [ebod_pkg::EVERY_W-1:0] every_r;
  logic                         wr;
  logic [2:0]                   idx;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite & pready;
  assign idx    = paddr[ebod_pkg::CFG_AW-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sens_r  <= ebod_pkg::SENS_RST;
      intv_r  <= ebod_pkg::INTV_RST;
      rel_r   <= ebod_pkg::REL_RST;
      mode_r  <= ebod_pkg::MODE_FRONT;
      every_r <= ebod_pkg::EVERY_RST;
    end else if (wr) begin
      case (idx)
        ebod_pkg::REG_SENS:  sens_r  <= pwdata[ebod_pkg::SENS_W-1:0];
        ebod_pkg::REG_INTV:  intv_r  <= pwdata[ebod_pkg::INTV_W-1:0];
        ebod_pkg::REG_REL:   rel_r   <= pwdata[ebod_pkg::REL_W-1:0];
        ebod_pkg::REG_MODE:  mode_r  <= pwdata[ebod_pkg::MODE_W-1:0];
        ebod_pkg::REG_EVERY: every_r <= pwdata[ebod_pkg::EVERY_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      ebod_pkg::REG_SENS:  prdata = ebod_pkg::CFG_DW'(sens_r);
      ebod_pkg::REG_INTV:  prdata = ebod_pkg::CFG_DW'(intv_r);
      ebod_pkg::REG_REL:   prdata = ebod_pkg::CFG_DW'(rel_r);
      ebod_pkg::REG_MODE:  prdata = ebod_pkg::CFG_DW'(mode_r);
      ebod_pkg::REG_EVERY: prdata = ebod_pkg::CFG_DW'(every_r);
      default:             prdata = '0;
    endcase
  end

  assign cfg.sens     = sens_r;
  assign cfg.interval = intv_r;
  assign cfg.rel      = rel_r;
  assign cfg.mode     = mode_r;
  assign cfg.every    = every_r;

  // A mode write also forces the orientation in the fixed modes.
  assign evt.mode_wr  = wr && (idx == ebod_pkg::REG_MODE);
  assign evt.mode_val = pwdata[ebod_pkg::MODE_W-1:0];

endmodule
`default_nettype wire

// File: hw/rtl/ebod_pre.sv
// Input register and the state-independent terms: filter products and peak fall.
`default_nettype none
module ebod_pre (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  input  wire logic [ebod_pkg::E_W-1:0]      in_e,
  input  wire logic                          in_have,
  input  wire logic [ebod_pkg::DT_W-1:0]     in_dt,
  output logic                               out_valid,
  output ebod_pkg::pre_t                     out_item
);

  // Stage 0: the accepted word.
  logic                          v0_r;
  logic [ebod_pkg::E_W-1:0]      e0_r;
  logic                          have0_r;
  logic [ebod_pkg::DT_W-1:0]     dt0_r;

  // Stage 1: products and the quotient estimate.
  logic                          v1_r;
  logic [ebod_pkg::E_W-1:0]      e1_r;
  logic                          have1_r;
  logic [ebod_pkg::DT_W-1:0]     dt1_r;
  logic [ebod_pkg::EAVG_W-1:0]   eavg1_r;
  logic [ebod_pkg::EFOL_W-1:0]   efol1_r;
  logic [ebod_pkg::N_W-1:0]      n1_r;
  logic [ebod_pkg::DEC_W-1:0]    qest1_r;

  // Stage 2: corrected peak fall.
  logic                          v2_r;
  ebod_pkg::pre_t                item2_r;

  logic [ebod_pkg::N_W-1:0]      n0;
  logic [44:0]                   qprod;
  logic [ebod_pkg::N_W-1:0]      rem1;
  logic [ebod_pkg::DEC_W-1:0]    dec1;

  // The estimate drops the low byte of the numerator and so may be one short.
  assign n0    = ebod_pkg::N_W'({dt0_r, 12'b0}) + ebod_pkg::N_W'(ebod_pkg::DEC_OFS);
  assign qprod = 45'(n0[ebod_pkg::N_W-1:8]) * 45'(ebod_pkg::DEC_RECIP);
  assign rem1  = n1_r - ebod_pkg::N_W'(qest1_r) * ebod_pkg::N_W'(ebod_pkg::DEC_DIV);
  assign dec1  = qest1_r + ebod_pkg::DEC_W'(rem1 >= ebod_pkg::N_W'(ebod_pkg::DEC_DIV));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v0_r <= in_valid;
      v1_r <= v0_r;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    e0_r    <= in_e;
    have0_r <= in_have;
    dt0_r   <= in_dt;

    e1_r    <= e0_r;
    have1_r <= have0_r;
    dt1_r   <= dt0_r;
    eavg1_r <= ebod_pkg::EAVG_W'(e0_r) * ebod_pkg::EAVG_W'(ebod_pkg::AVG_ALPHA);
    efol1_r <= ebod_pkg::EFOL_W'(e0_r) * ebod_pkg::EFOL_W'(ebod_pkg::FOL_ALPHA);
    n1_r    <= n0;
    qest1_r <= qprod[32 +: ebod_pkg::DEC_W];

    item2_r.e      <= e1_r;
    item2_r.have   <= have1_r;
    item2_r.dt     <= dt1_r;
    item2_r.eavg_m <= eavg1_r;
    item2_r.efol_m <= efol1_r;
    item2_r.dec    <= dec1;
  end

  assign out_valid = v2_r;
  assign out_item  = item2_r;

endmodule
`default_nettype wire

// File: hw/rtl/ebod_track.sv
// Energy average and meter followers, then the threshold product.
`default_nettype none
module ebod_track (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire ebod_pkg::cfg_t                cfg,
  input  wire logic                          in_valid,
  input  wire ebod_pkg::pre_t                in_item,
  output logic                               out_valid,
  output ebod_pkg::trk_t                     out_item
);

  logic [ebod_pkg::AVG_W-1:0]    avg_r;
  logic [ebod_pkg::FOL_W-1:0]    fol_r;
  logic [ebod_pkg::FOL_W-1:0]    pk_r;

  // Stage 3 word.
  logic                          v3_r;
  logic [ebod_pkg::E_W-1:0]      e3_r;
  logic                          have3_r;
  logic [ebod_pkg::DT_W-1:0]     dt3_r;
  logic [ebod_pkg::AVG_W-1:0]    avg3_r;
  logic [ebod_pkg::FOL_W-1:0]    fol3_r;
  logic [ebod_pkg::DEC_W-1:0]    dec3_r;

  // Stage 4 word.
  logic                          v4_r;
  ebod_pkg::trk_t                item4_r;

  logic [40:0]                   avg_sum;
  logic [ebod_pkg::AVG_W-1:0]    avg_nxt;
  logic [15:0]                   fol_k;
  logic [36:0]                   fol_add;
  logic [36:0]                   fol_sum;
  logic [ebod_pkg::FOL_W-1:0]    e16;
  logic [ebod_pkg::FOL_W-1:0]    fol_nxt;
  logic [ebod_pkg::FOL_W-1:0]    pk_nxt;

  assign avg_sum = 41'(avg_r) * 41'(ebod_pkg::AVG_KEEP)
                 + 41'({in_item.eavg_m, 8'b0}) + 41'(ebod_pkg::RND_HALF);
  assign avg_nxt = in_item.have ? avg_sum[16 +: ebod_pkg::AVG_W] : avg_r;

  // With audio the follower jumps up to a higher energy and otherwise blends toward it; without it, it only decays.
  assign fol_k   = in_item.have ? ebod_pkg::FOL_KEEP : cfg.rel;
  assign fol_add = in_item.have ? 37'({in_item.efol_m, 4'b0}) : '0;
  assign fol_sum = 37'(fol_r) * 37'(fol_k) + fol_add + 37'(ebod_pkg::RND_HALF);
  assign e16     = {in_item.e, 4'b0};
  assign fol_nxt = (in_item.have && (e16 > fol_r)) ? e16 : fol_sum[16 +: ebod_pkg::FOL_W];

  always_comb begin
    if (have3_r && (fol3_r > pk_r)) begin
      pk_nxt = fol3_r;
    end else if (pk_r > ebod_pkg::FOL_W'(dec3_r)) begin
      pk_nxt = pk_r - ebod_pkg::FOL_W'(dec3_r);
    end else begin
      pk_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      avg_r <= '0;
      fol_r <= '0;
      pk_r  <= '0;
      v3_r  <= 1'b0;
      v4_r  <= 1'b0;
    end else begin
      v3_r <= in_valid;
      v4_r <= v3_r;
      if (in_valid) begin
        avg_r <= avg_nxt;
        fol_r <= fol_nxt;
      end
      if (v3_r) begin
        pk_r <= pk_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    e3_r    <= in_item.e;
    have3_r <= in_item.have;
    dt3_r   <= in_item.dt;
    avg3_r  <= avg_nxt;
    fol3_r  <= fol_nxt;
    dec3_r  <= in_item.dec;

    item4_r.e    <= e3_r;
    item4_r.have <= have3_r;
    item4_r.dt   <= dt3_r;
    item4_r.fol  <= fol3_r;
    item4_r.pk   <= pk_nxt;
    item4_r.prod <= ebod_pkg::PROD_W'(avg3_r) * ebod_pkg::PROD_W'(cfg.sens);
  end

  assign out_valid = v4_r;
  assign out_item  = item4_r;

endmodule
`default_nettype wire

// File: hw/rtl/ebod_decide.sv
// Beat decision, refractory and idle timers, beat count and orientation.
`default_nettype none
module ebod_decide (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire ebod_pkg::cfg_t                cfg,
  input  wire ebod_pkg::cfg_evt_t            evt,
  input  wire logic                          in_valid,
  input  wire ebod_pkg::trk_t                in_item,
  output logic                               res_valid,
  output ebod_pkg::res_t                     res
);

  logic                               started_r;
  logic [ebod_pkg::SINCE_W-1:0]       since_r;
  logic [ebod_pkg::IDLE_W-1:0]        idle_r;
  logic [ebod_pkg::CNT_W-1:0]         beats_r;
  logic [ebod_pkg::PHASE_W-1:0]       phase_r;
  logic                               facing_r;
  logic                               res_valid_r;
  ebod_pkg::res_t                     res_r;

  logic [ebod_pkg::SINCE_W:0]         s_sum;
  logic [ebod_pkg::SINCE_W-1:0]       s_sat;
  logic                               det;
  logic [ebod_pkg::IDLE_W:0]          i_sum;
  logic [ebod_pkg::IDLE_W-1:0]        i_sat;
  logic                               i_kick;
  logic [ebod_pkg::IDLE_W-1:0]        i_left;
  logic                               kick;
  logic                               first;
  logic [ebod_pkg::PHASE_W:0]         st0;
  logic [ebod_pkg::PHASE_W:0]         st1;
  logic [ebod_pkg::PHASE_W:0]         st2;
  logic [ebod_pkg::CNT_W-1:0]         beats_nxt;
  logic [ebod_pkg::PROD_W:0]          t_sum;
  logic [18:0]                        t_q;
  logic [ebod_pkg::MTR_W-1:0]         thresh;
  logic [ebod_pkg::FOL_W:0]           me_sum;
  logic [ebod_pkg::FOL_W:0]           mp_sum;

  // One beat applied to {phase, facing}.
  function automatic logic [ebod_pkg::PHASE_W:0] beat_step(
    input logic [ebod_pkg::PHASE_W:0]  st,
    input logic [ebod_pkg::EVERY_W-1:0] every,
    input logic [ebod_pkg::MODE_W-1:0]  mode
  );
    logic [ebod_pkg::EVERY_W-1:0] lim;
    logic [ebod_pkg::PHASE_W:0]   nxt;
    logic                         flip;
    logic                         f;
    lim = every;
    if (lim < ebod_pkg::EVERY_MIN) begin
      lim = ebod_pkg::EVERY_MIN;
    end else if (lim > ebod_pkg::EVERY_MAX) begin
      lim = ebod_pkg::EVERY_MAX;
    end
    nxt  = {1'b0, st[ebod_pkg::PHASE_W:1]} + 1'b1;
    flip = ebod_pkg::EVERY_W'(nxt) >= lim;
    case (mode)
      ebod_pkg::MODE_TOGGLE: f = st[0] ^ flip;
      ebod_pkg::MODE_FRONT:  f = 1'b1;
      default:               f = 1'b0;
    endcase
    return {(flip ? {ebod_pkg::PHASE_W{1'b0}} : nxt[ebod_pkg::PHASE_W-1:0]), f};
  endfunction

  // Refractory timer runs only with audio.
  assign s_sum = (ebod_pkg::SINCE_W+1)'(since_r) + (ebod_pkg::SINCE_W+1)'(in_item.dt);
  assign s_sat = (s_sum > (ebod_pkg::SINCE_W+1)'(ebod_pkg::SINCE_MAX))
               ? ebod_pkg::SINCE_MAX : s_sum[ebod_pkg::SINCE_W-1:0];
  assign det   = (ebod_pkg::PROD_W'({in_item.e, 20'b0}) > in_item.prod)
              && (in_item.e > ebod_pkg::MIN_E)
              && (s_sat > ebod_pkg::REFRACT_US);

  // Idle timer runs only without audio and drives the self-triggered beat.
  assign i_sum  = (ebod_pkg::IDLE_W+1)'(idle_r) + (ebod_pkg::IDLE_W+1)'(in_item.dt);
  assign i_sat  = (i_sum > (ebod_pkg::IDLE_W+1)'(ebod_pkg::IDLE_MAX))
                ? ebod_pkg::IDLE_MAX : i_sum[ebod_pkg::IDLE_W-1:0];
  assign i_kick = i_sat >= ebod_pkg::IDLE_W'(cfg.interval);
  assign i_left = i_kick ? (i_sat - ebod_pkg::IDLE_W'(cfg.interval)) : i_sat;

  assign kick  = in_item.have ? det : i_kick;
  assign first = !started_r;

  // The first word after reset forces a beat ahead of the detector's own.
  assign st0 = {phase_r, facing_r};
  assign st1 = first ? beat_step(st0, cfg.every, cfg.mode) : st0;
  assign st2 = kick ? beat_step(st1, cfg.every, cfg.mode) : st1;
  assign beats_nxt = beats_r + ebod_pkg::CNT_W'(first) + ebod_pkg::CNT_W'(kick);

  assign t_sum  = (ebod_pkg::PROD_W+1)'(in_item.prod) + (ebod_pkg::PROD_W+1)'(1 << 19);
  assign t_q    = t_sum[20 +: 19];
  assign thresh = !in_item.have ? '0
                : ((t_q > 19'(ebod_pkg::MTR_MAX)) ? ebod_pkg::MTR_MAX
                   : t_q[ebod_pkg::MTR_W-1:0]);

  assign me_sum = (ebod_pkg::FOL_W+1)'(in_item.fol) + (ebod_pkg::FOL_W+1)'(8);
  assign mp_sum = (ebod_pkg::FOL_W+1)'(in_item.pk) + (ebod_pkg::FOL_W+1)'(8);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r   <= 1'b0;
      since_r     <= ebod_pkg::SINCE_RST;
      idle_r      <= '0;
      beats_r     <= '0;
      phase_r     <= '0;
      facing_r    <= 1'b1;
      res_valid_r <= 1'b0;
    end else begin
      res_valid_r <= in_valid;
      if (in_valid) begin
        started_r <= 1'b1;
        beats_r   <= beats_nxt;
        phase_r   <= st2[ebod_pkg::PHASE_W:1];
        facing_r  <= st2[0];
        if (in_item.have) begin
          since_r <= det ? '0 : s_sat;
        end else begin
          idle_r <= i_left;
        end
      end
      if (evt.mode_wr) begin
        if (evt.mode_val == ebod_pkg::MODE_FRONT) begin
          facing_r <= 1'b1;
        end else if (evt.mode_val == ebod_pkg::MODE_DOWN) begin
          facing_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      res_r.beat            <= first | kick;
      res_r.beat_total      <= beats_nxt;
      res_r.front           <= st2[0];
      res_r.meter_energy    <= me_sum[4 +: ebod_pkg::MTR_W];
      res_r.meter_peak      <= mp_sum[4 +: ebod_pkg::MTR_W];
      res_r.meter_threshold <= thresh;
    end
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

endmodule
`default_nettype wire

// File: hw/rtl/ebod_outq.sv
// Result queue with an in-flight counter that gates input acceptance.
`default_nettype none
module ebod_outq #(
  parameter int DEPTH = ebod_pkg::OQ_DEPTH
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_accept,
  output logic                               in_ready,
  input  wire logic                          wr_valid,
  input  wire ebod_pkg::res_t                wr_data,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output ebod_pkg::res_t                     out_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);

  ebod_pkg::res_t       mem [DEPTH];
  logic [PTR_W-1:0]     wr_ptr_r;
  logic [PTR_W-1:0]     rd_ptr_r;
  logic [CW-1:0]        count_r;
  logic [CW-1:0]        inflight_r;
  logic                 rd;

  // Every accepted word owns a queue slot until its result is taken.
  assign in_ready  = inflight_r < CW'(DEPTH);
  assign out_valid = count_r != '0;
  assign rd        = out_valid & out_ready;
  assign out_data  = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      count_r    <= '0;
      inflight_r <= '0;
    end else begin
      inflight_r <= inflight_r + CW'(in_accept) - CW'(rd);
      count_r    <= count_r + CW'(wr_valid) - CW'(rd);
      if (wr_valid) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (rd) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_valid) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/energy_beat_onset_detector.sv
// Energy beat onset detector: one result word per input word.
// An accepted word passes the pre, track and decide stages and the result queue before its result shows on out_tvalid.
// Throughput: one word per cycle while results are read, set by the average and follower
// recurrences; the result queue of OUT_DEPTH words bounds the words in flight.
// Reset (synchronous, rst_n low): registers to defaults, detector state to its reset values,
// first word after reset forces one beat; no clearing pass.
`default_nettype none
module energy_beat_onset_detector #(
  parameter int OUT_DEPTH = ebod_pkg::OQ_DEPTH
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // band_energy[15:0], elapsed_us[32:16], zero fill[39:33]
  input  wire logic [39:0]                   in_tdata,
  // audio_valid[0]
  input  wire logic                          in_tuser,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  // beat[0], beat_total[32:1], front_facing[33], meter_energy[49:34],
  // meter_peak[65:50], meter_threshold[81:66], zero fill[87:82]
  output logic [87:0]                        out_tdata,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  input  wire logic                          cfg_psel,
  input  wire logic                          cfg_penable,
  input  wire logic                          cfg_pwrite,
  input  wire logic [ebod_pkg::CFG_AW-1:0]   cfg_paddr,
  input  wire logic [ebod_pkg::CFG_DW-1:0]   cfg_pwdata,
  output logic      [ebod_pkg::CFG_DW-1:0]   cfg_prdata,
  output logic                               cfg_pready
);

  ebod_pkg::cfg_t      cfg;
  ebod_pkg::cfg_evt_t  evt;
  logic                in_acc;
  logic                pre_valid;
  ebod_pkg::pre_t      pre_item;
  logic                trk_valid;
  ebod_pkg::trk_t      trk_item;
  logic                res_valid;
  ebod_pkg::res_t      res;
  ebod_pkg::res_t      q_data;

  assign in_acc = in_tvalid & in_tready;

  ebod_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg),
    .evt     (evt)
  );

  ebod_pre u_pre (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_acc),
    .in_e      (in_tdata[15:0]),
    .in_have   (in_tuser),
    .in_dt     (in_tdata[32:16]),
    .out_valid (pre_valid),
    .out_item  (pre_item)
  );

  ebod_track u_track (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (pre_valid),
    .in_item   (pre_item),
    .out_valid (trk_valid),
    .out_item  (trk_item)
  );

  ebod_decide u_decide (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .evt       (evt),
    .in_valid  (trk_valid),
    .in_item   (trk_item),
    .res_valid (res_valid),
    .res       (res)
  );

  ebod_outq #(
    .DEPTH (OUT_DEPTH)
  ) u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_accept (in_acc),
    .in_ready  (in_tready),
    .wr_valid  (res_valid),
    .wr_data   (res),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (q_data)
  );

  assign out_tdata = {6'b0, q_data.meter_threshold, q_data.meter_peak, q_data.meter_energy,
                      q_data.front, q_data.beat_total, q_data.beat};

endmodule
`default_nettype wire
